@@ sv/process_table_scheduler_top_macros.svh @@
// Assertion macros used by the task table scheduler controller
`ifndef PROCESS_TABLE_SCHEDULER_TOP_MACROS_SVH
`define PROCESS_TABLE_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pts assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pts assertion failed");

`endif

@@ sv/pts_pkg.sv @@
// Package: types, codes and helpers of the task table scheduler
`default_nettype none
package pts_pkg;

	localparam int SLOTS_DEF  = 64;
	localparam int LEVELS_DEF = 5;

	localparam logic [6:0] PRIO_MAX   = 7'd100;
	localparam logic [4:0] LCOUNT_MAX = 5'd31;
	localparam logic [6:0] PRIO_RST   = 7'd10;

	// request kinds
	localparam logic [2:0] K_CREATE = 3'd0;
	localparam logic [2:0] K_SETST  = 3'd1;
	localparam logic [2:0] K_SETPR  = 3'd2;
	localparam logic [2:0] K_TICK   = 3'd3;
	localparam logic [2:0] K_PICK   = 3'd4;
	localparam logic [2:0] K_REAP   = 3'd5;

	// task states
	localparam logic [2:0] TS_UNUSED   = 3'd0;
	localparam logic [2:0] TS_EMBRYO   = 3'd1;
	localparam logic [2:0] TS_SLEEPING = 3'd2;
	localparam logic [2:0] TS_RUNNABLE = 3'd3;
	localparam logic [2:0] TS_RUNNING  = 3'd4;
	localparam logic [2:0] TS_ZOMBIE   = 3'd5;

	// policies
	localparam logic [1:0] MODE_RR   = 2'd0;
	localparam logic [1:0] MODE_FCFS = 2'd1;
	localparam logic [1:0] MODE_PRIO = 2'd2;
	localparam logic [1:0] MODE_MLFQ = 2'd3;

	// configuration register indexes
	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_PRIO = 1'b1;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SINGLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] init_prio;
	} cfg_t;

	// one table entry
	typedef struct packed {
		logic [2:0]  state;
		logic [30:0] ident;
		logic [6:0]  prio;
		logic [31:0] created;
		logic [31:0] ended;
		logic [31:0] run;
		logic [31:0] sleep;
		logic [2:0]  level;
		logic [4:0]  lticks;
	} rec_t;

	typedef struct packed {
		logic        accepted;
		logic [5:0]  chosen_slot;
		logic [30:0] task_id;
		logic [6:0]  old_priority;
		logic        should_yield;
		logic [31:0] wait_time;
		logic [31:0] run_time;
	} res_t;

	function automatic logic [6:0] sat_prio(input logic [6:0] v);
		return (v > PRIO_MAX) ? PRIO_MAX : v;
	endfunction

	// ticks a task stays at one feedback level
	function automatic logic [4:0] quantum(input logic [2:0] lvl);
		logic [4:0] q;
		q = (lvl >= 3'd5) ? LCOUNT_MAX : (5'd1 << lvl);
		return q;
	endfunction

endpackage
`default_nettype wire

@@ sv/pts_ram.sv @@
// Generic single write, single registered read RAM
`default_nettype none
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ sv/pts_unit.sv @@
// Shared compare and tick-update unit applied to one entry per cycle
`default_nettype none
module pts_unit #(
	parameter int LEVELS = pts_pkg::LEVELS_DEF
) (
	input  wire logic [1:0]  mode,
	input  wire pts_pkg::rec_t cand,
	input  wire pts_pkg::rec_t best,
	output logic             better,
	output pts_pkg::rec_t    ticked
);

	logic [4:0] lt;

	// candidate preferred over current best under the active policy
	always_comb begin
		case (mode)
			pts_pkg::MODE_FCFS: better = cand.created < best.created;
			pts_pkg::MODE_PRIO: better = cand.prio < best.prio;
			default: begin
				if (cand.level != best.level) begin
					better = cand.level < best.level;
				end else begin
					better = cand.created < best.created;
				end
			end
		endcase
	end

	// entry after one tick
	always_comb begin
		ticked = cand;
		lt     = cand.lticks;
		if (cand.state == pts_pkg::TS_RUNNING) begin
			ticked.run = cand.run + 32'd1;
			if (mode == pts_pkg::MODE_MLFQ) begin
				if (lt < pts_pkg::LCOUNT_MAX) begin
					lt = lt + 5'd1;
				end
				ticked.lticks = lt;
				if ((4'(cand.level) + 4'd1 < 4'(LEVELS)) &&
						(lt >= pts_pkg::quantum(cand.level))) begin
					ticked.level  = cand.level + 3'd1;
					ticked.lticks = 5'd0;
				end
			end
		end else if (cand.state == pts_pkg::TS_SLEEPING) begin
			ticked.sleep = cand.sleep + 32'd1;
		end
	end

endmodule
`default_nettype wire

@@ sv/pts_ctrl.sv @@
// Sequencer: serves single-slot requests and scans the task table through one RAM read port and the shared unit
`include "process_table_scheduler_top_macros.svh"
`default_nettype none
module pts_ctrl #(
	parameter int SLOTS  = pts_pkg::SLOTS_DEF,
	parameter int LEVELS = pts_pkg::LEVELS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pts_pkg::cfg_t  cfg,
	input  wire logic           start,
	output logic                busy,
	input  wire logic [2:0]     kind,
	input  wire logic [5:0]     slot,
	input  wire logic [2:0]     new_state,
	input  wire logic [6:0]     new_priority,
	output logic                done,
	output pts_pkg::res_t       res
);

	localparam int AW    = $clog2(SLOTS);
	localparam int IDX_W = $clog2(SLOTS + 1);

	pts_pkg::fsm_t state_q, state_d;
	logic [2:0]  kind_q;
	logic [5:0]  slot_q;
	logic [2:0]  nst_q;
	logic [6:0]  npr_q;
	logic        inside_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [AW-1:0] addr_s1;
	logic          val_s1, vld_s1;
	logic          found_q, found_d;
	logic [AW-1:0] best_addr_q, best_addr_d;
	pts_pkg::rec_t best_q, best_d;
	logic [AW-1:0] rr_q, rr_d;
	logic [31:0]   now_q, now_d;
	logic [30:0]   nid_q, nid_d;
	logic [SLOTS-1:0] vld_q;
	logic          done_q, done_d;
	pts_pkg::res_t res_q, res_d;

	logic          accept;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	pts_pkg::rec_t rd_rec, wr_rec, cur, ticked;
	logic          better;
	logic [AW:0]   rr_sum;
	logic [AW:0]   rr_next;

	assign accept = start && (state_q == pts_pkg::FSM_IDLE);
	assign busy   = (state_q != pts_pkg::FSM_IDLE);
	assign done   = done_q;
	assign res    = res_q;

	pts_ram #(.WIDTH($bits(pts_pkg::rec_t)), .DEPTH(SLOTS)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_rec)
	);

	// entry never written reads as unused
	always_comb begin
		cur = rd_rec;
		if (!vld_s1) begin
			cur.state = pts_pkg::TS_UNUSED;
		end
	end

	pts_unit #(.LEVELS(LEVELS)) u_unit (
		.mode   (cfg.mode),
		.cand   (cur),
		.best   (best_q),
		.better (better),
		.ticked (ticked)
	);

	// scan address, circular from the round robin pointer in that mode
	always_comb begin
		rr_sum = {1'b0, rr_q} + (AW+1)'(idx_q);
		if ((kind_q == pts_pkg::K_PICK) && (cfg.mode == pts_pkg::MODE_RR)) begin
			if (rr_sum >= (AW+1)'(SLOTS)) begin
				rr_sum = rr_sum - (AW+1)'(SLOTS);
			end
		end else begin
			rr_sum = (AW+1)'(idx_q);
		end
		rr_next = {1'b0, best_addr_q} + (AW+1)'(1);
		if (rr_next >= (AW+1)'(SLOTS)) begin
			rr_next = '0;
		end
	end

	// next state, RAM control and result
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		found_d     = found_q;
		best_addr_d = best_addr_q;
		best_d      = best_q;
		rr_d        = rr_q;
		now_d       = now_q;
		nid_d       = nid_q;
		done_d      = 1'b0;
		res_d       = '0;
		rd_en       = 1'b0;
		rd_addr     = rr_sum[AW-1:0];
		wr_en       = 1'b0;
		wr_addr     = addr_s1;
		wr_rec      = cur;
		case (state_q)
			pts_pkg::FSM_IDLE: begin
				if (accept) begin
					idx_d   = '0;
					found_d = 1'b0;
					rd_addr = AW'(slot);
					rd_en   = 1'b1;
					if ((kind == pts_pkg::K_CREATE) || (kind == pts_pkg::K_TICK) ||
							(kind == pts_pkg::K_PICK)) begin
						state_d = pts_pkg::FSM_SCAN;
						rd_en   = 1'b0;
					end else begin
						state_d = pts_pkg::FSM_SINGLE;
					end
				end
			end
			pts_pkg::FSM_SINGLE: begin
				state_d = pts_pkg::FSM_IDLE;
				done_d  = 1'b1;
				wr_addr = AW'(slot_q);
				case (kind_q)
					pts_pkg::K_SETST: begin
						if (inside_q && (nst_q <= pts_pkg::TS_ZOMBIE)) begin
							wr_en        = 1'b1;
							wr_rec.state = nst_q;
							if (nst_q == pts_pkg::TS_ZOMBIE) begin
								wr_rec.ended = now_q;
							end
							res_d.accepted    = 1'b1;
							res_d.chosen_slot = slot_q;
						end
					end
					pts_pkg::K_SETPR: begin
						if (inside_q && (cur.state != pts_pkg::TS_UNUSED)) begin
							wr_en              = 1'b1;
							wr_rec.prio        = npr_q;
							res_d.accepted     = 1'b1;
							res_d.chosen_slot  = slot_q;
							res_d.old_priority = cur.prio;
							res_d.should_yield = npr_q < cur.prio;
						end
					end
					pts_pkg::K_REAP: begin
						if (inside_q && (cur.state == pts_pkg::TS_ZOMBIE)) begin
							wr_en             = 1'b1;
							wr_rec.state      = pts_pkg::TS_UNUSED;
							res_d.accepted    = 1'b1;
							res_d.chosen_slot = slot_q;
							res_d.task_id     = cur.ident;
							res_d.wait_time   = cur.ended - cur.created - cur.run - cur.sleep;
							res_d.run_time    = cur.run;
						end
					end
					default: begin
						res_d = '0;
					end
				endcase
			end
			pts_pkg::FSM_SCAN: begin
				// issue one read a cycle
				if (idx_q != IDX_W'(SLOTS)) begin
					rd_en = 1'b1;
					idx_d = idx_q + IDX_W'(1);
				end else if (!val_s1) begin
					state_d = pts_pkg::FSM_FINISH;
				end
				// handle the entry read last cycle
				if (val_s1) begin
					case (kind_q)
						pts_pkg::K_CREATE: begin
							if (!found_q && (cur.state == pts_pkg::TS_UNUSED)) begin
								found_d     = 1'b1;
								best_addr_d = addr_s1;
							end
						end
						pts_pkg::K_TICK: begin
							if ((cur.state == pts_pkg::TS_RUNNING) ||
									(cur.state == pts_pkg::TS_SLEEPING)) begin
								wr_en  = 1'b1;
								wr_rec = ticked;
							end
						end
						default: begin
							if ((cur.state == pts_pkg::TS_RUNNABLE) && (!found_q ||
									((cfg.mode != pts_pkg::MODE_RR) && better))) begin
								found_d     = 1'b1;
								best_addr_d = addr_s1;
								best_d      = cur;
							end
						end
					endcase
				end
			end
			pts_pkg::FSM_FINISH: begin
				state_d = pts_pkg::FSM_IDLE;
				done_d  = 1'b1;
				wr_addr = best_addr_q;
				case (kind_q)
					pts_pkg::K_CREATE: begin
						if (found_q) begin
							wr_en             = 1'b1;
							wr_rec            = '0;
							wr_rec.state      = pts_pkg::TS_EMBRYO;
							wr_rec.ident      = nid_q;
							wr_rec.prio       = cfg.init_prio;
							wr_rec.created    = now_q;
							nid_d             = nid_q + 31'd1;
							res_d.accepted    = 1'b1;
							res_d.chosen_slot = 6'(best_addr_q);
							res_d.task_id     = nid_q;
						end
					end
					pts_pkg::K_TICK: begin
						now_d          = now_q + 32'd1;
						res_d.accepted = 1'b1;
					end
					default: begin
						if (found_q) begin
							wr_en        = 1'b1;
							wr_rec       = best_q;
							wr_rec.state = pts_pkg::TS_RUNNING;
							if (cfg.mode == pts_pkg::MODE_RR) begin
								rr_d = rr_next[AW-1:0];
							end
							res_d.accepted    = 1'b1;
							res_d.chosen_slot = 6'(best_addr_q);
							res_d.task_id     = best_q.ident;
						end
					end
				endcase
			end
			default: begin
				state_d = pts_pkg::FSM_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::FSM_IDLE;
			idx_q   <= '0;
			val_s1  <= 1'b0;
			found_q <= 1'b0;
			rr_q    <= '0;
			now_q   <= '0;
			nid_q   <= 31'd1;
			vld_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			val_s1  <= rd_en && (state_q == pts_pkg::FSM_SCAN);
			found_q <= found_d;
			rr_q    <= rr_d;
			now_q   <= now_d;
			nid_q   <= nid_d;
			done_q  <= done_d;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			slot_q   <= slot;
			nst_q    <= new_state;
			npr_q    <= pts_pkg::sat_prio(new_priority);
			inside_q <= ({3'b0, slot} < 9'(SLOTS));
		end
		addr_s1     <= rd_addr;
		vld_s1      <= vld_q[rd_addr];
		best_addr_q <= best_addr_d;
		best_q      <= best_d;
		res_q       <= res_d;
	end

	`PTS_ASSERT_NEXT(a_accept_busy, accept, busy)
	`PTS_ASSERT_NOW(a_write_busy, wr_en, busy)
	`PTS_ASSERT_NEXT(a_finish_done, state_q == pts_pkg::FSM_FINISH, done_q)
	`PTS_ASSERT_NOW(a_scan_rd, val_s1, state_q == pts_pkg::FSM_SCAN)

endmodule
`default_nettype wire

@@ sv/process_table_scheduler_top.sv @@
// Task table scheduler: set state, set priority and reap touch one slot;
// create, tick and pick scan the whole table (one table read per cycle on one RAM port).
// One item at a time: busy is high from accept until the result cycle.
// Result shows for one cycle with done; the receiver cannot stall.
// Async reset: all slots unused, policy feedback queue, initial priority 10,
// tick 0, next id 1, round robin pointer 0.
`default_nettype none
module process_table_scheduler_top #(
	parameter int SLOTS  = pts_pkg::SLOTS_DEF,
	parameter int LEVELS = pts_pkg::LEVELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  kind,
	input  wire logic [5:0]  slot,
	input  wire logic [2:0]  new_state,
	input  wire logic [6:0]  new_priority,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data,
	output logic             done,
	output logic             accepted,
	output logic [5:0]       chosen_slot,
	output logic [30:0]      task_id,
	output logic [6:0]       old_priority,
	output logic             should_yield,
	output logic [31:0]      wait_time,
	output logic [31:0]      run_time
);

	pts_pkg::cfg_t cfg_q;
	pts_pkg::res_t res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= pts_pkg::MODE_MLFQ;
			cfg_q.init_prio <= pts_pkg::PRIO_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pts_pkg::CFG_MODE: cfg_q.mode      <= cfg_data[1:0];
				pts_pkg::CFG_PRIO: cfg_q.init_prio <= pts_pkg::sat_prio(cfg_data);
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	pts_ctrl #(.SLOTS(SLOTS), .LEVELS(LEVELS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.slot         (slot),
		.new_state    (new_state),
		.new_priority (new_priority),
		.done         (done),
		.res          (res)
	);

	assign accepted     = res.accepted;
	assign chosen_slot  = res.chosen_slot;
	assign task_id      = res.task_id;
	assign old_priority = res.old_priority;
	assign should_yield = res.should_yield;
	assign wait_time    = res.wait_time;
	assign run_time     = res.run_time;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the task table scheduler
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int NSLOT = 64;
	localparam int NLEVEL = 5;
	localparam int N_RANDOM = 1800;
	localparam longint CYCLE_LIMIT = 1_500_000;

	// scheduler table predictor and queue of expected results
	class sched_scoreboard;
		logic [2:0]  st[NSLOT];
		logic [30:0] ident[NSLOT];
		logic [6:0]  prio[NSLOT];
		logic [31:0] created[NSLOT];
		logic [31:0] ended[NSLOT];
		logic [31:0] run[NSLOT];
		logic [31:0] sleep[NSLOT];
		logic [2:0]  level[NSLOT];
		logic [4:0]  lticks[NSLOT];
		logic [31:0] now;
		logic [30:0] next_id;
		logic [5:0]  rr_ptr;
		logic [1:0]  mode;
		logic [6:0]  init_prio;
		pts_pkg::res_t pending[$];
		int          errors;

		function void clear();
			for (int i = 0; i < NSLOT; i++) begin
				st[i] = pts_pkg::TS_UNUSED; ident[i] = '0; prio[i] = '0; created[i] = '0;
				ended[i] = '0; run[i] = '0; sleep[i] = '0; level[i] = '0; lticks[i] = '0;
			end
			now = '0; next_id = 31'd1; rr_ptr = '0;
			mode = pts_pkg::MODE_MLFQ; init_prio = pts_pkg::PRIO_RST;
			pending.delete(); errors = 0;
		endfunction

		function void write_reg(logic idx, logic [6:0] v);
			if (idx == pts_pkg::CFG_MODE) mode = v[1:0];
			else init_prio = (v > pts_pkg::PRIO_MAX) ? pts_pkg::PRIO_MAX : v;
		endfunction

		function bit prefer(int a, int b);
			if (mode == pts_pkg::MODE_FCFS) return created[a] < created[b];
			if (mode == pts_pkg::MODE_PRIO) return prio[a] < prio[b];
			if (level[a] != level[b]) return level[a] < level[b];
			return created[a] < created[b];
		endfunction

		function int choose();
			int best;
			int s;
			best = -1;
			if (mode == pts_pkg::MODE_RR) begin
				for (int k = 0; k < NSLOT; k++) begin
					s = (rr_ptr + k) % NSLOT;
					if (st[s] == pts_pkg::TS_RUNNABLE) begin
						rr_ptr = 6'((s + 1) % NSLOT);
						return s;
					end
				end
				return -1;
			end
			for (int k = 0; k < NSLOT; k++)
				if (st[k] == pts_pkg::TS_RUNNABLE && (best < 0 || prefer(k, best))) best = k;
			return best;
		endfunction

		function void advance();
			logic [4:0] q;
			now++;
			for (int s = 0; s < NSLOT; s++) begin
				if (st[s] == pts_pkg::TS_RUNNING) begin
					run[s]++;
					if (mode == pts_pkg::MODE_MLFQ) begin
						if (lticks[s] < pts_pkg::LCOUNT_MAX) lticks[s]++;
						q = (level[s] >= 3'd5) ? pts_pkg::LCOUNT_MAX : (5'd1 << level[s]);
						if (level[s] + 1 < NLEVEL && lticks[s] >= q) begin
							level[s]++;
							lticks[s] = '0;
						end
					end
				end else if (st[s] == pts_pkg::TS_SLEEPING) begin
					sleep[s]++;
				end
			end
		endfunction

		// note an accepted request and queue its expected result
		function void note_request(logic [2:0] k, logic [5:0] sl, logic [2:0] ns,
				logic [6:0] np);
			pts_pkg::res_t r;
			int p;
			logic [6:0] npr;
			r = '0;
			npr = (np > pts_pkg::PRIO_MAX) ? pts_pkg::PRIO_MAX : np;
			case (k)
				pts_pkg::K_CREATE: begin
					p = -1;
					for (int s = NSLOT - 1; s >= 0; s--) if (st[s] == pts_pkg::TS_UNUSED) p = s;
					if (p >= 0) begin
						st[p] = pts_pkg::TS_EMBRYO; ident[p] = next_id; next_id++;
						prio[p] = init_prio; created[p] = now; ended[p] = '0;
						run[p] = '0; sleep[p] = '0; level[p] = '0; lticks[p] = '0;
						r.accepted = 1'b1; r.chosen_slot = 6'(p); r.task_id = ident[p];
					end
				end
				pts_pkg::K_SETST: if (ns <= pts_pkg::TS_ZOMBIE) begin
					st[sl] = ns;
					if (ns == pts_pkg::TS_ZOMBIE) ended[sl] = now;
					r.accepted = 1'b1; r.chosen_slot = sl;
				end
				pts_pkg::K_SETPR: if (st[sl] != pts_pkg::TS_UNUSED) begin
					r.accepted = 1'b1; r.chosen_slot = sl; r.old_priority = prio[sl];
					r.should_yield = npr < prio[sl];
					prio[sl] = npr;
				end
				pts_pkg::K_TICK: begin
					advance();
					r.accepted = 1'b1;
				end
				pts_pkg::K_PICK: begin
					p = choose();
					if (p >= 0) begin
						st[p] = pts_pkg::TS_RUNNING;
						r.accepted = 1'b1; r.chosen_slot = 6'(p); r.task_id = ident[p];
					end
				end
				pts_pkg::K_REAP: if (st[sl] == pts_pkg::TS_ZOMBIE) begin
					r.accepted = 1'b1; r.chosen_slot = sl; r.task_id = ident[sl];
					r.wait_time = ended[sl] - created[sl] - run[sl] - sleep[sl];
					r.run_time = run[sl];
					st[sl] = pts_pkg::TS_UNUSED;
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(pts_pkg::res_t got);
			pts_pkg::res_t exp;
			if (pending.size() == 0) begin
				report_error("result with nothing expected", 0, 0);
				return;
			end
			exp = pending.pop_front();
			if (got.accepted != exp.accepted)
				report_error("accepted", got.accepted, exp.accepted);
			if (got.chosen_slot != exp.chosen_slot)
				report_error("chosen_slot", got.chosen_slot, exp.chosen_slot);
			if (got.task_id != exp.task_id)
				report_error("task_id", got.task_id, exp.task_id);
			if (got.old_priority != exp.old_priority)
				report_error("old_priority", got.old_priority, exp.old_priority);
			if (got.should_yield != exp.should_yield)
				report_error("should_yield", got.should_yield, exp.should_yield);
			if (got.wait_time != exp.wait_time)
				report_error("wait_time", got.wait_time, exp.wait_time);
			if (got.run_time != exp.run_time)
				report_error("run_time", got.run_time, exp.run_time);
		endfunction

		function void report_error(string what, longint got, longint exp);
			$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
			errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [2:0] kind = 0;
	logic [5:0] slot = 0;
	logic [2:0] new_state = 0;
	logic [6:0] new_priority = 0;
	logic cfg_valid = 0;
	logic cfg_index = 0;
	logic [6:0] cfg_data = 0;
	logic busy, cfg_ready, done, accepted, should_yield;
	logic [5:0] chosen_slot;
	logic [30:0] task_id;
	logic [6:0] old_priority;
	logic [31:0] wait_time, run_time;

	sched_scoreboard sb = new();
	longint cycles = 0;
	bit allow_gaps = 1;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	process_table_scheduler_top dut (.*);

	// result monitor and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_result({accepted, chosen_slot, task_id, old_priority, should_yield,
				wait_time, run_time});
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// start drops on the negedge after acceptance; the next item starts on a later negedge, after an optional random gap
	task automatic send(logic [2:0] k, logic [5:0] sl, logic [2:0] ns, logic [6:0] np);
		int gap;
		gap = allow_gaps ? $urandom_range(0, 18) : 0;
		@(negedge clk);
		repeat (gap) @(negedge clk);
		start <= 1; kind <= k; slot <= sl; new_state <= ns; new_priority <= np;
		do @(posedge clk); while (busy);
		sb.note_request(k, sl, ns, np);
		@(negedge clk);
		start <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (NSLOT + 8) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [6:0] v);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// slot that was created at some point (never read an unwritten entry)
	function automatic logic [5:0] live_slot(bit ever[NSLOT]);
		int idx[$];
		for (int i = 0; i < NSLOT; i++) if (ever[i]) idx.push_back(i);
		if (idx.size() == 0) return '0;
		return 6'(idx[$urandom_range(0, idx.size() - 1)]);
	endfunction

	bit ever[NSLOT];

	task automatic random_phase(int n);
		int r;
		logic [5:0] sl;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			sl = live_slot(ever);
			if (r < 12) begin
				send(pts_pkg::K_CREATE, 6'($urandom), 3'($urandom), 7'($urandom));
				for (int s = 0; s < NSLOT; s++) if (sb.st[s] != pts_pkg::TS_UNUSED) ever[s] = 1;
			end else if (r < 30) begin
				// mostly make tasks runnable; otherwise any state code, invalid ones included
				send(pts_pkg::K_SETST, sl, ($urandom_range(0, 9) < 6) ? pts_pkg::TS_RUNNABLE :
					3'($urandom_range(0, 7)), 7'($urandom));
			end else if (r < 33) begin
				// touch any slot, but never revive an unwritten entry
				send(pts_pkg::K_SETST, 6'($urandom),
					($urandom_range(0, 1) != 0) ? pts_pkg::TS_UNUSED : 3'd7, 7'($urandom));
			end else if (r < 43) begin
				send(pts_pkg::K_SETPR, ($urandom_range(0, 3) == 0) ? 6'($urandom) : sl,
					3'($urandom), 7'($urandom));
			end else if (r < 68) begin
				send(pts_pkg::K_TICK, 6'($urandom), 3'($urandom), 7'($urandom));
			end else if (r < 85) begin
				send(pts_pkg::K_PICK, 6'($urandom), 3'($urandom), 7'($urandom));
			end else if (r < 97) begin
				send(pts_pkg::K_REAP, ($urandom_range(0, 3) == 0) ? 6'($urandom) : sl,
					3'($urandom), 7'($urandom));
			end else begin
				send(3'($urandom_range(6, 7)), 6'($urandom), 3'($urandom), 7'($urandom));
			end
		end
	endtask

	initial begin
		sb.clear();
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset config, empty table, fill, extremes, zombie/reap
		send(pts_pkg::K_PICK, '0, '0, '0);
		send(pts_pkg::K_REAP, 6'd63, '0, '0);
		send(pts_pkg::K_SETPR, 6'd63, '0, 7'd127);
		for (int i = 0; i < 65; i++) send(pts_pkg::K_CREATE, '0, '0, '0);
		for (int s = 0; s < NSLOT; s++) ever[s] = 1;
		send(pts_pkg::K_SETST, 6'd63, 3'd7, '0);
		send(pts_pkg::K_SETST, 6'd63, pts_pkg::TS_RUNNABLE, '0);
		send(pts_pkg::K_SETST, 6'd0, pts_pkg::TS_SLEEPING, '0);
		send(pts_pkg::K_SETPR, 6'd63, '0, 7'd127);
		send(pts_pkg::K_SETPR, 6'd63, '0, 7'd0);
		send(pts_pkg::K_PICK, '0, '0, '0);
		repeat (40) send(pts_pkg::K_TICK, '0, '0, '0);
		send(pts_pkg::K_SETST, 6'd63, pts_pkg::TS_ZOMBIE, '0);
		send(pts_pkg::K_SETST, 6'd0, pts_pkg::TS_ZOMBIE, '0);
		send(pts_pkg::K_REAP, 6'd63, '0, '0);
		send(pts_pkg::K_REAP, 6'd0, '0, '0);
		send(pts_pkg::K_REAP, 6'd0, '0, '0);
		send(3'd6, '0, '0, '0);
		send(3'd7, 6'd63, 3'd7, 7'd127);
		drain();

		// random phases across policies and initial priorities
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(pts_pkg::CFG_MODE, 7'((ph < 4) ? ph : $urandom_range(0, 3)));
			write_cfg(pts_pkg::CFG_PRIO, (ph == 0) ? 7'd0 : (ph == 1) ? 7'd127 :
				(ph == 2) ? 7'd100 : 7'($urandom));
			allow_gaps = (ph != 3);
			random_phase(N_RANDOM / 6);
			// hold off until every result is back
			drain();
		end

		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/pts_pkg.sv
sv/pts_ram.sv
sv/pts_unit.sv
sv/pts_ctrl.sv
sv/process_table_scheduler_top.sv
verif/tb.sv
